// ----- design/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, constants and helpers of the i2c master byte engine
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int TICK_COUNTER_BITS = 16;
  localparam int PHASE_TICKS_W     = 16;
  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST = 16'd125;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef logic [TICK_COUNTER_BITS-1:0] tick_cnt_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_code_t;

  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       nack_last;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_stage_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_byte;
  } res_t;

  // phase length masked to the counter width, zero taken as one
  function automatic tick_cnt_t unit_ticks(input logic [PHASE_TICKS_W-1:0] pt);
    tick_cnt_t u;
    u = '0;
    for (int i = 0; i < TICK_COUNTER_BITS; i++) begin
      if (i < PHASE_TICKS_W) begin
        u[i] = pt[i];
      end
    end
    if (u == '0) begin
      u = tick_cnt_t'(1);
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- design/i2cm_if.sv -----
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// command, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;
  logic       nack_last;
  logic       sda_in;

  modport source (output valid, output operation, output data_byte,
                  output nack_last, output sda_in, input ready);
  modport sink   (input valid, input operation, input data_byte,
                  input nack_last, input sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic       ack_received;
  logic [7:0] read_byte;

  modport source (output valid, output scl_out, output sda_out, output sda_drive,
                  output busy_res, output done_res, output ack_received,
                  output read_byte, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input sda_drive,
                  input busy_res, input done_res, input ack_received,
                  input read_byte, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_ticks;

  modport source (output valid, output phase_ticks, input ready);
  modport sink   (input valid, input phase_ticks, output ready);
endinterface

`default_nettype wire

// ----- design/i2cm_in_reg.sv -----
// ----------------------------------------------------------------------------
// i2cm_in_reg
// input register stage for command items
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_in_reg
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  i2cm_cmd_if.sink        cmd,
  input  wire logic       advance,
  output cmd_stage_t      stage
);

  logic valid;
  cmd_t item;

  assign cmd.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item <= '{operation: cmd.operation, data_byte: cmd.data_byte,
                nack_last: cmd.nack_last, sda_in: cmd.sda_in};
    end
  end

  assign stage = '{valid: valid, cmd: item};

endmodule

`default_nettype wire

// ----- design/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// bus phase sequencer with pin state and registered result
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq
  import i2cm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_stage_t               stage,
  output logic                          advance,
  input  wire logic [PHASE_TICKS_W-1:0] phase_ticks,
  i2cm_res_if.source                    res
);

  cmd_state_t cmd, cmd_next;
  tick_cnt_t  phase_cnt, phase_cnt_next;
  logic [2:0] step, step_next;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic [7:0] shifter, shifter_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       sda_en, sda_en_next;
  logic       ack, ack_next;
  logic       nack_pend, nack_pend_next;
  logic [7:0] read_hold, read_hold_next;
  logic       done;
  logic       fire;
  logic       res_valid;
  res_t       res_q;

  logic [TICK_COUNTER_BITS:0] cnt_inc;
  logic [TICK_COUNTER_BITS:0] unit_ext;
  logic [3:0]                 bit_inc;
  logic [7:0]                 shift_left;
  logic                       phase_end;

  assign advance = !res_valid || res.ready;
  assign fire    = stage.valid && advance;

  assign cnt_inc    = {1'b0, phase_cnt} + {{TICK_COUNTER_BITS{1'b0}}, 1'b1};
  assign unit_ext   = {1'b0, unit_ticks(phase_ticks)};
  assign phase_end  = cnt_inc >= unit_ext;
  assign bit_inc    = bit_cnt + 4'd1;
  assign shift_left = {shifter[6:0], 1'b0};

  always_comb begin
    cmd_next       = cmd;
    phase_cnt_next = phase_cnt;
    step_next      = step;
    bit_cnt_next   = bit_cnt;
    shifter_next   = shifter;
    scl_next       = scl;
    sda_next       = sda;
    sda_en_next    = sda_en;
    ack_next       = ack;
    nack_pend_next = nack_pend;
    read_hold_next = read_hold;
    done           = 1'b0;
    if (cmd != CMD_IDLE) begin
      if (!phase_end) begin
        phase_cnt_next = cnt_inc[TICK_COUNTER_BITS-1:0];
      end else begin
        phase_cnt_next = '0;
        step_next      = step + 3'd1;
        unique case (cmd)
          CMD_START: begin
            if (step == 3'd0) begin
              sda_en_next = 1'b1;
              sda_next    = 1'b0;
            end else begin
              scl_next = 1'b0;
              done     = 1'b1;
            end
          end
          CMD_STOP: begin
            if (step == 3'd0) begin
              scl_next = 1'b1;
            end else if (step == 3'd1) begin
              sda_en_next = 1'b1;
              sda_next    = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          CMD_WRITE: begin
            unique case (step)
              3'd0, 3'd3: scl_next = 1'b1;
              3'd1: ;
              3'd2: begin
                scl_next     = 1'b0;
                shifter_next = shift_left;
                bit_cnt_next = bit_inc;
                if (bit_inc < BITS_PER_BYTE) begin
                  sda_en_next = 1'b1;
                  sda_next    = shift_left[7];
                  step_next   = 3'd0;
                end else begin
                  sda_en_next = 1'b0;
                  sda_next    = 1'b1;
                end
              end
              3'd4: ack_next = !stage.cmd.sda_in;
              3'd5: scl_next = 1'b0;
              default: begin
                sda_en_next = 1'b1;
                sda_next    = 1'b0;
                done        = 1'b1;
              end
            endcase
          end
          CMD_READ: begin
            unique case (step)
              3'd0, 3'd2, 3'd4, 3'd6: ;
              3'd1: begin
                scl_next     = 1'b1;
                shifter_next = {shifter[6:0], stage.cmd.sda_in};
              end
              3'd3: begin
                scl_next     = 1'b0;
                bit_cnt_next = bit_inc;
                if (bit_inc < BITS_PER_BYTE) begin
                  step_next = 3'd0;
                end else if (!nack_pend) begin
                  sda_en_next = 1'b1;
                  sda_next    = 1'b0;
                end
              end
              3'd5: scl_next = 1'b1;
              default: begin
                sda_en_next    = 1'b0;
                sda_next       = 1'b1;
                scl_next       = 1'b0;
                read_hold_next = shifter;
                done           = 1'b1;
              end
            endcase
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          cmd_next     = CMD_IDLE;
          step_next    = '0;
          bit_cnt_next = '0;
        end
      end
    end else begin
      phase_cnt_next = '0;
      step_next      = '0;
      bit_cnt_next   = '0;
      unique case (stage.cmd.operation)
        OP_START: cmd_next = CMD_START;
        OP_STOP: begin
          cmd_next    = CMD_STOP;
          sda_en_next = 1'b1;
          sda_next    = 1'b0;
        end
        OP_WRITE: begin
          cmd_next     = CMD_WRITE;
          shifter_next = stage.cmd.data_byte;
          sda_en_next  = 1'b1;
          sda_next     = stage.cmd.data_byte[7];
        end
        OP_READ: begin
          cmd_next       = CMD_READ;
          shifter_next   = '0;
          nack_pend_next = stage.cmd.nack_last;
          sda_en_next    = 1'b0;
          sda_next       = 1'b1;
        end
        default: begin
          phase_cnt_next = phase_cnt;
          step_next      = step;
          bit_cnt_next   = bit_cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= CMD_IDLE;
      phase_cnt <= '0;
      step      <= '0;
      bit_cnt   <= '0;
      shifter   <= '0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      sda_en    <= 1'b1;
      ack       <= 1'b0;
      nack_pend <= 1'b0;
      read_hold <= '0;
      res_valid <= 1'b0;
    end else begin
      if (fire) begin
        cmd       <= cmd_next;
        phase_cnt <= phase_cnt_next;
        step      <= step_next;
        bit_cnt   <= bit_cnt_next;
        shifter   <= shifter_next;
        scl       <= scl_next;
        sda       <= sda_next;
        sda_en    <= sda_en_next;
        ack       <= ack_next;
        nack_pend <= nack_pend_next;
        read_hold <= read_hold_next;
      end
      if (advance) begin
        res_valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= '{scl_out:      scl_next,
                 sda_out:      sda_en_next ? sda_next : 1'b1,
                 sda_drive:    sda_en_next,
                 busy_res:     cmd_next != CMD_IDLE,
                 done_res:     done,
                 ack_received: ack_next,
                 read_byte:    read_hold_next};
    end
  end

  assign res.valid        = res_valid;
  assign res.scl_out      = res_q.scl_out;
  assign res.sda_out      = res_q.sda_out;
  assign res.sda_drive    = res_q.sda_drive;
  assign res.busy_res     = res_q.busy_res;
  assign res.done_res     = res_q.done_res;
  assign res.ack_received = res_q.ack_received;
  assign res.read_byte    = res_q.read_byte;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && done) |=> (cmd == CMD_IDLE && res_valid && res.done_res && !res.busy_res))
    else $error("done without return to idle");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd != CMD_IDLE && !done) |=> (cmd == $past(cmd)))
    else $error("command changed while busy");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_IDLE) |-> (step == 3'd0 && bit_cnt == 4'd0))
    else $error("idle with sequence state left over");

  a_bit_bound: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd != CMD_IDLE) |=> (bit_cnt <= BITS_PER_BYTE))
    else $error("bit counter past one byte");
`endif

endmodule

`default_nettype wire

// ----- design/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// i2c master that runs start, stop, byte write and byte read commands,
// advanced by one tick item per bus timebase cycle
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    operation, data_byte, nack_last, sda_in
//   res      out  valid/ready    scl_out, sda_out, sda_drive, busy_res,
//                                done_res, ack_received, read_byte
//   cfg      in   valid/ready    phase_ticks
//
// one result item per command item, offered once it has passed the input
// register and the result register; one item per cycle sustained while res
// is ready: input register, one step of the phase sequencer, result register
// a stalled result holds the sequencer; the input register takes one more item
// synchronous reset returns the bus to idle, scl and sda high and driven
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  i2cm_cmd_if.sink   cmd,
  i2cm_res_if.source res,
  i2cm_cfg_if.sink   cfg
);

  logic [PHASE_TICKS_W-1:0] phase_ticks;
  cmd_stage_t               stage;
  logic                     advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
    end else if (cfg.valid) begin
      phase_ticks <= cfg.phase_ticks;
    end
  end

  i2cm_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .stage   (stage)
  );

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .advance     (advance),
    .phase_ticks (phase_ticks),
    .res         (res)
  );

endmodule

`default_nettype wire
